// ----- rtl/tensor_axis_reduce_sum_macros.svh -----
// assertion macros shared by the reduce-sum rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TENSOR_AXIS_REDUCE_SUM_MACROS_SVH
`define TENSOR_AXIS_REDUCE_SUM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TARS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// antecedent implies consequent in the next cycle
`define TARS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

// condition must never hold
`define TARS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- rtl/tars_pkg.sv -----
// shared types, constants and helpers for the tensor axis reduce-sum block
// no dependencies
package tars_pkg;

  localparam int ELEM_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int OUTER_W     = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COUNT = 3'd3;

  // element width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  typedef struct packed {
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // per-item control carried from front to back
  typedef struct packed {
    logic       first;       // depth position 0: overwrite the partial sum
    logic       emit;        // last depth position: sum goes out
    logic       last;        // final output of the tensor
    logic [1:0] width_code;
  } item_ctl_t;

  function automatic logic [ELEM_W-1:0] width_mask(input logic [1:0] code);
    logic [ELEM_W-1:0] m;
    unique case (code)
      WIDTH_8:  m = 64'h0000_0000_0000_00FF;
      WIDTH_16: m = 64'h0000_0000_0000_FFFF;
      WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
      WIDTH_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/tars_front.sv -----
// front end: configuration registers, tensor position counters, item classification
// depends on tars_pkg
module tars_front #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int AW           = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tars_pkg::cfg_wr_t             cfg_wr,
  input  logic                          in_valid,
  input  logic [tars_pkg::ELEM_W-1:0]   in_element_value,
  input  logic                          q_full,
  output logic                          push,
  output logic [tars_pkg::ELEM_W-1:0]   push_elem,
  output logic [AW-1:0]                 push_slot,
  output tars_pkg::item_ctl_t           push_ctl
);
  import tars_pkg::*;

  localparam int CW = (AW + 1 > OUTER_W) ? AW + 1 : OUTER_W;

  logic [1:0]         width_code_r;
  logic [COUNT_W-1:0] inner_count_r;
  logic [COUNT_W-1:0] depth_count_r;
  logic [OUTER_W-1:0] outer_count_r;

  logic [AW-1:0]      outer_pos_r, outer_pos_nxt;
  logic [COUNT_W-1:0] depth_pos_r, depth_pos_nxt;
  logic [COUNT_W-1:0] inner_pos_r, inner_pos_nxt;

  logic [CW-1:0]      n_outer;
  logic [COUNT_W-1:0] depth_m1, inner_m1;
  logic               last_outer, last_depth, last_inner;
  logic               accept;

  // effective counts: zero acts as one, outer saturates at the buffer depth
  always_comb begin
    n_outer = (outer_count_r == '0) ? CW'(1) : CW'(outer_count_r);
    if (n_outer > CW'(BUFFER_DEPTH)) begin
      n_outer = CW'(BUFFER_DEPTH);
    end
    depth_m1 = (depth_count_r == '0) ? '0 : depth_count_r - COUNT_W'(1);
    inner_m1 = (inner_count_r == '0) ? '0 : inner_count_r - COUNT_W'(1);
  end

  assign last_outer = (CW'(outer_pos_r) == n_outer - CW'(1));
  assign last_depth = (depth_pos_r >= depth_m1);
  assign last_inner = (inner_pos_r >= inner_m1);
  assign accept     = in_valid && !q_full;

  // classify the item and hand it to the queue
  assign push                = accept;
  assign push_elem           = in_element_value & width_mask(width_code_r);
  assign push_slot           = outer_pos_r;
  assign push_ctl.first      = (depth_pos_r == '0);
  assign push_ctl.emit       = last_depth;
  assign push_ctl.last       = last_depth && last_inner && last_outer;
  assign push_ctl.width_code = width_code_r;

  // position advance: outer fastest, then depth, then inner
  always_comb begin
    outer_pos_nxt = outer_pos_r;
    depth_pos_nxt = depth_pos_r;
    inner_pos_nxt = inner_pos_r;
    if (last_outer) begin
      outer_pos_nxt = '0;
      if (last_depth) begin
        depth_pos_nxt = '0;
        inner_pos_nxt = last_inner ? '0 : inner_pos_r + COUNT_W'(1);
      end else begin
        depth_pos_nxt = depth_pos_r + COUNT_W'(1);
      end
    end else begin
      outer_pos_nxt = outer_pos_r + AW'(1);
    end
  end

  // writes to the four configuration registers restart the tensor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_code_r  <= WIDTH_64;
      inner_count_r <= COUNT_W'(1);
      depth_count_r <= COUNT_W'(1);
      outer_count_r <= OUTER_W'(1);
      outer_pos_r   <= '0;
      depth_pos_r   <= '0;
      inner_pos_r   <= '0;
    end else if (cfg_wr.wr_en) begin
      unique case (cfg_wr.index)
        REG_WIDTH_CODE: begin
          width_code_r <= cfg_wr.data[1:0];
          outer_pos_r  <= '0;
          depth_pos_r  <= '0;
          inner_pos_r  <= '0;
        end
        REG_INNER_COUNT: begin
          inner_count_r <= cfg_wr.data[COUNT_W-1:0];
          outer_pos_r   <= '0;
          depth_pos_r   <= '0;
          inner_pos_r   <= '0;
        end
        REG_DEPTH_COUNT: begin
          depth_count_r <= cfg_wr.data[COUNT_W-1:0];
          outer_pos_r   <= '0;
          depth_pos_r   <= '0;
          inner_pos_r   <= '0;
        end
        REG_OUTER_COUNT: begin
          outer_count_r <= cfg_wr.data[OUTER_W-1:0];
          outer_pos_r   <= '0;
          depth_pos_r   <= '0;
          inner_pos_r   <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      outer_pos_r <= outer_pos_nxt;
      depth_pos_r <= depth_pos_nxt;
      inner_pos_r <= inner_pos_nxt;
    end
  end

endmodule

// ----- rtl/tars_queue.sv -----
// short item queue between front and back ends
// depends on tars_pkg
module tars_queue #(
  parameter int AW = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [tars_pkg::ELEM_W-1:0]   push_elem,
  input  logic [AW-1:0]                 push_slot,
  input  tars_pkg::item_ctl_t           push_ctl,
  output logic                          full,
  input  logic                          pop,
  output logic                          head_valid,
  output logic [tars_pkg::ELEM_W-1:0]   head_elem,
  output logic [AW-1:0]                 head_slot,
  output tars_pkg::item_ctl_t           head_ctl
);
  import tars_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [ELEM_W-1:0] elem_q [QUEUE_DEPTH];
  logic [AW-1:0]     slot_q [QUEUE_DEPTH];
  item_ctl_t         ctl_q  [QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full       = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_elem  = elem_q[rd_ptr_r];
  assign head_slot  = slot_q[rd_ptr_r];
  assign head_ctl   = ctl_q[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      elem_q[wr_ptr_r] <= push_elem;
      slot_q[wr_ptr_r] <= push_slot;
      ctl_q[wr_ptr_r]  <= push_ctl;
    end
  end

endmodule

// ----- rtl/tars_back.sv -----
// back end: partial-sum buffer, accumulate stage with bypass, output register
// depends on tars_pkg and tensor_axis_reduce_sum_macros.svh
`include "tensor_axis_reduce_sum_macros.svh"

module tars_back #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int AW           = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [tars_pkg::ELEM_W-1:0]   q_elem,
  input  logic [AW-1:0]                 q_slot,
  input  tars_pkg::item_ctl_t           q_ctl,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tars_pkg::ELEM_W-1:0]   out_sum_value,
  output logic                          out_last_output
);
  import tars_pkg::*;

  logic [ELEM_W-1:0] sum_mem [BUFFER_DEPTH];

  logic              b_valid_r;
  logic [ELEM_W-1:0] b_elem_r;
  logic [AW-1:0]     b_slot_r;
  item_ctl_t         b_ctl_r;
  logic              b_fwd_r;
  logic [ELEM_W-1:0] b_fwd_val_r;
  logic [ELEM_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [ELEM_W-1:0] out_sum_r;
  logic              out_last_r;

  logic              out_free, b_fire, b_load, fwd_hit;
  logic [ELEM_W-1:0] operand, sum_b;

  // stage handshake
  assign out_free = !out_valid_r || !out_stall;
  assign b_fire   = b_valid_r && (!b_ctl_r.emit || out_free);
  assign b_load   = q_valid && (!b_valid_r || b_fire);
  assign q_pop    = b_load;
  // the item leaving writes the slot the incoming item reads
  assign fwd_hit  = b_fire && (b_slot_r == q_slot);

  // accumulate: overwrite at depth 0, else add to stored or bypassed sum
  always_comb begin
    if (b_ctl_r.first) begin
      operand = '0;
    end else if (b_fwd_r) begin
      operand = b_fwd_val_r;
    end else begin
      operand = rd_data_r;
    end
    sum_b = (operand + b_elem_r) & width_mask(b_ctl_r.width_code);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_load) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire && b_ctl_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage payload and output register
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_elem_r    <= q_elem;
      b_slot_r    <= q_slot;
      b_ctl_r     <= q_ctl;
      b_fwd_r     <= fwd_hit;
      b_fwd_val_r <= sum_b;
    end
    if (b_fire && b_ctl_r.emit) begin
      out_sum_r  <= sum_b;
      out_last_r <= b_ctl_r.last;
    end
  end

  // partial-sum buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (b_fire) begin
      sum_mem[b_slot_r] <= sum_b;
    end
    if (b_load) begin
      rd_data_r <= sum_mem[q_slot];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sum_value   = out_sum_r;
  assign out_last_output = out_last_r;

  // checks
  `TARS_ASSERT_NEXT(a_emit_reaches_out, clk, rst_n, b_fire && b_ctl_r.emit, out_valid_r)
  `TARS_ASSERT_NEXT(a_bypass_matches_write, clk, rst_n, b_load, b_fwd_r == ($past(b_fire) && ($past(b_slot_r) == b_slot_r)))
  `TARS_ASSERT_NEVER(a_sum_upper_zero, clk, rst_n, b_valid_r && ((sum_b & ~width_mask(b_ctl_r.width_code)) != '0))

endmodule

// ----- rtl/tensor_axis_reduce_sum.sv -----
// top level of the streaming tensor axis reduce-sum block
// depends on tars_pkg, tars_front, tars_queue, tars_back
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    in_element_value
//   out       output      out_valid / out_stall  out_sum_value, out_last_output
//   cfg       input       cfg_wr_en              cfg_index, cfg_data
//
// one element per cycle sustained while out_stall is low; the front counters, queue and the single
// accumulate stage each move one item per cycle, limited by the one-write one-read buffer port
// a result passes the queue, the accumulate stage register and the output register before out_valid
// rst_n is synchronous and active low; buffer contents are undefined until written
// in_stall rises only when the four-entry queue is full; out_stall backs up into it
module tensor_axis_reduce_sum #(
  parameter int BUFFER_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tars_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tars_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tars_pkg::ELEM_W-1:0]     in_element_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tars_pkg::ELEM_W-1:0]     out_sum_value,
  output logic                            out_last_output
);
  import tars_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  cfg_wr_t           cfg_wr;
  logic              push, q_full, q_pop, q_valid;
  logic [ELEM_W-1:0] push_elem, q_elem;
  logic [AW-1:0]     push_slot, q_slot;
  item_ctl_t         push_ctl, q_ctl;

  assign cfg_wr.wr_en = cfg_wr_en;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;
  assign in_stall     = q_full;

  tars_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr           (cfg_wr),
    .in_valid         (in_valid),
    .in_element_value (in_element_value),
    .q_full           (q_full),
    .push             (push),
    .push_elem        (push_elem),
    .push_slot        (push_slot),
    .push_ctl         (push_ctl)
  );

  tars_queue #(
    .AW (AW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_elem  (push_elem),
    .push_slot  (push_slot),
    .push_ctl   (push_ctl),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_elem  (q_elem),
    .head_slot  (q_slot),
    .head_ctl   (q_ctl)
  );

  tars_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_elem          (q_elem),
    .q_slot          (q_slot),
    .q_ctl           (q_ctl),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sum_value   (out_sum_value),
    .out_last_output (out_last_output)
  );

endmodule
